// ----- src/tcce_pkg.sv -----
// Shared types, codes and constants of the TCP client connection engine.
// No dependencies; every other file of the block imports this package.
package tcce_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxPayload = 1004;
  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned PlenW      = 10;

  localparam logic [15:0] ClientPortRst = 16'd49152;
  localparam logic [31:0] InitialSeqRst = 32'h1234_5678;
  localparam logic [15:0] WindowRst     = 16'd4096;
  localparam logic [15:0] TimeoutRst    = 16'd300;

  localparam logic [7:0] FlFin = 8'h01;
  localparam logic [7:0] FlSyn = 8'h02;
  localparam logic [7:0] FlPsh = 8'h08;
  localparam logic [7:0] FlAck = 8'h10;

  localparam int unsigned FinBit = 0;
  localparam int unsigned SynBit = 1;
  localparam int unsigned AckBit = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIENT_PORT     = 2'd0,
    CFG_INITIAL_SEQ     = 2'd1,
    CFG_WINDOW_SIZE     = 2'd2,
    CFG_CONNECT_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_CONNECT = 3'd0,
    OP_SEND    = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_SEGMENT = 3'd3,
    OP_TICK    = 3'd4,
    OP_NONE    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_CONNECTED = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_IGNORED   = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    PH_CLOSED      = 5'b00001,
    PH_SYN_SENT    = 5'b00010,
    PH_ESTABLISHED = 5'b00100,
    PH_CLOSE_WAIT  = 5'b01000,
    PH_TIME_WAIT   = 5'b10000
  } phase_e;

  localparam logic [2:0] CodeClosed      = 3'd0;
  localparam logic [2:0] CodeSynSent     = 3'd1;
  localparam logic [2:0] CodeEstablished = 3'd2;
  localparam logic [2:0] CodeCloseWait   = 3'd3;
  localparam logic [2:0] CodeTimeWait    = 3'd4;

  typedef struct packed {
    logic [15:0] client_port;
    logic [31:0] initial_seq;
    logic [15:0] window_size;
    logic [15:0] connect_timeout;
  } tcce_cfg_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    op_e         op;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] length;
    logic        too_long;
    logic        hdr_ok;
    logic        doff_ok;
    logic        pay_nz;
    logic        fin;
    logic        syn;
    logic        ack;
    logic [31:0] ack_pay;
    logic [31:0] ack_pay1;
    logic [31:0] ack_seq1;
  } tcce_item_t;

  typedef struct packed {
    logic             emit;
    logic [7:0]       flags;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [31:0]      dst_ip;
    logic [15:0]      window;
    logic [PlenW-1:0] plen;
    status_e          status;
    logic [2:0]       phase;
  } tcce_result_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_CLOSED:      code = CodeClosed;
      PH_SYN_SENT:    code = CodeSynSent;
      PH_ESTABLISHED: code = CodeEstablished;
      PH_CLOSE_WAIT:  code = CodeCloseWait;
      PH_TIME_WAIT:   code = CodeTimeWait;
      default:        code = CodeClosed;
    endcase
    return code;
  endfunction

endpackage

// ----- src/tcce_front.sv -----
// Front end: accepts input beats, decodes the kind and precomputes all
// state-independent checks and sums. Depends on tcce_pkg.
module tcce_front (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             kind_i,
  input  logic [31:0]            peer_ip_i,
  input  logic [15:0]            peer_port_i,
  input  logic [15:0]            seg_dst_port_i,
  input  logic [31:0]            seg_seq_i,
  input  logic [7:0]             seg_flags_i,
  input  logic [3:0]             seg_data_offset_i,
  input  logic [15:0]            length_i,
  input  logic [15:0]            client_port_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output tcce_pkg::tcce_item_t   q_item_o
);
  import tcce_pkg::*;

  logic [15:0] doff_bytes;
  logic [15:0] payload;
  op_e         op;

  assign doff_bytes = {10'd0, seg_data_offset_i, 2'b00};
  assign payload    = length_i - doff_bytes;

  always_comb begin
    if (kind_i inside {OP_CONNECT, OP_SEND, OP_CLOSE, OP_SEGMENT, OP_TICK}) begin
      op = op_e'(kind_i);
    end else begin
      op = OP_NONE;
    end
  end

  always_comb begin
    q_item_o.op        = op;
    q_item_o.peer_ip   = peer_ip_i;
    q_item_o.peer_port = peer_port_i;
    q_item_o.length    = length_i;
    q_item_o.too_long  = length_i > 16'(MaxPayload);
    q_item_o.hdr_ok    = (length_i >= 16'(HdrBytes)) && (seg_dst_port_i == client_port_i);
    q_item_o.doff_ok   = (doff_bytes >= 16'(HdrBytes)) && (doff_bytes <= length_i);
    q_item_o.pay_nz    = payload != 16'd0;
    q_item_o.fin       = seg_flags_i[FinBit];
    q_item_o.syn       = seg_flags_i[SynBit];
    q_item_o.ack       = seg_flags_i[AckBit];
    q_item_o.ack_pay   = seg_seq_i + {16'd0, payload};
    q_item_o.ack_pay1  = seg_seq_i + {16'd0, payload} + 32'd1;
    q_item_o.ack_seq1  = seg_seq_i + 32'd1;
  end

  // Hold the sender while the queue has no room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ----- src/tcce_queue.sv -----
// Short register queue of classified items between front and back.
// Depends on tcce_pkg for the item type.
module tcce_queue #(
  parameter int unsigned Depth = tcce_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tcce_pkg::tcce_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output tcce_pkg::tcce_item_t item_o
);
  import tcce_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tcce_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push while queue full");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

// ----- src/tcce_back.sv -----
// Back end: owns the connection state, executes one classified item per
// cycle unless stalled, and registers its result. Depends on tcce_pkg.
module tcce_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcce_pkg::tcce_cfg_t    cfg_i,
  input  logic                   q_valid_i,
  input  tcce_pkg::tcce_item_t   q_item_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tcce_pkg::tcce_result_t result_o
);
  import tcce_pkg::*;

  phase_e       phase_q, phase_d;
  logic         active_q, active_d;
  logic [31:0]  peer_ip_q, peer_ip_d;
  logic [15:0]  peer_port_q, peer_port_d;
  logic [31:0]  send_seq_q, send_seq_d;
  logic [31:0]  recv_ack_q, recv_ack_d;
  logic [15:0]  wait_q, wait_d;
  logic         out_valid_q;
  tcce_result_t out_q, res;

  logic         seg_en;
  logic [7:0]   seg_flags;
  logic [31:0]  seg_seq;
  logic [PlenW-1:0] seg_plen;
  logic [31:0]  ack_new;
  status_e      status;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d     = phase_q;
    active_d    = active_q;
    peer_ip_d   = peer_ip_q;
    peer_port_d = peer_port_q;
    send_seq_d  = send_seq_q;
    recv_ack_d  = recv_ack_q;
    wait_d      = wait_q;
    seg_en      = 1'b0;
    seg_flags   = 8'd0;
    seg_seq     = send_seq_q;
    seg_plen    = '0;
    status      = ST_IGNORED;

    // Ack after an in-window segment: payload moves it, FIN adds one.
    if (q_item_i.pay_nz) begin
      ack_new = q_item_i.fin ? q_item_i.ack_pay1 : q_item_i.ack_pay;
    end else begin
      ack_new = q_item_i.fin ? recv_ack_q + 32'd1 : recv_ack_q;
    end

    case (q_item_i.op)
      OP_CONNECT: begin
        peer_ip_d   = q_item_i.peer_ip;
        peer_port_d = q_item_i.peer_port;
        recv_ack_d  = 32'd0;
        wait_d      = 16'd0;
        phase_d     = PH_SYN_SENT;
        active_d    = 1'b1;
        seg_en      = 1'b1;
        seg_flags   = FlSyn;
        seg_seq     = cfg_i.initial_seq;
        send_seq_d  = cfg_i.initial_seq + 32'd1;
        status      = ST_OK;
      end
      OP_SEND: begin
        if (phase_q != PH_ESTABLISHED) begin
          status = ST_REFUSED;
        end else begin
          if (q_item_i.too_long) begin
            status = ST_TOO_LONG;
          end else begin
            seg_en    = 1'b1;
            seg_flags = FlPsh | FlAck;
            seg_plen  = q_item_i.length[PlenW-1:0];
            status    = ST_OK;
          end
          // Sequence advances even when the data is dropped.
          send_seq_d = send_seq_q + {16'd0, q_item_i.length};
        end
      end
      OP_CLOSE: begin
        if (phase_q == PH_ESTABLISHED) begin
          seg_en     = 1'b1;
          seg_flags  = FlFin | FlAck;
          send_seq_d = send_seq_q + 32'd1;
          phase_d    = PH_CLOSE_WAIT;
          status     = ST_OK;
        end
        active_d = 1'b0;
      end
      OP_SEGMENT: begin
        if (q_item_i.hdr_ok && active_q && (q_item_i.peer_ip == peer_ip_q)) begin
          if (phase_q == PH_SYN_SENT) begin
            if (q_item_i.syn && q_item_i.ack) begin
              recv_ack_d = q_item_i.ack_seq1;
              seg_en     = 1'b1;
              seg_flags  = FlAck;
              phase_d    = PH_ESTABLISHED;
              status     = ST_CONNECTED;
            end
          end else if (phase_q == PH_ESTABLISHED && q_item_i.doff_ok) begin
            recv_ack_d = ack_new;
            status     = ST_OK;
            if (q_item_i.fin) begin
              seg_en    = 1'b1;
              seg_flags = FlFin | FlAck;
              phase_d   = PH_TIME_WAIT;
            end else if (q_item_i.ack) begin
              seg_en    = 1'b1;
              seg_flags = FlAck;
            end
          end
        end
      end
      OP_TICK: begin
        if (phase_q == PH_SYN_SENT) begin
          wait_d = wait_q + 16'd1;
          if (wait_d >= cfg_i.connect_timeout) begin
            phase_d  = PH_CLOSED;
            active_d = 1'b0;
            status   = ST_TIMEOUT;
          end else begin
            status = ST_OK;
          end
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    res        = '0;
    res.status = status;
    res.phase  = phase_code(phase_d);
    if (seg_en) begin
      res.emit     = 1'b1;
      res.flags    = seg_flags;
      res.seq      = seg_seq;
      res.ack      = seg_flags[AckBit] ? recv_ack_d : 32'd0;
      res.src_port = cfg_i.client_port;
      res.dst_port = peer_port_d;
      res.dst_ip   = peer_ip_d;
      res.window   = cfg_i.window_size;
      res.plen     = seg_plen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLOSED;
      active_q    <= 1'b0;
      peer_ip_q   <= '0;
      peer_port_q <= '0;
      send_seq_q  <= '0;
      recv_ack_q  <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q     <= phase_d;
        active_q    <= active_d;
        peer_ip_q   <= peer_ip_d;
        peer_port_q <= peer_port_d;
        send_seq_q  <= send_seq_d;
        recv_ack_q  <= recv_ack_d;
        wait_q      <= wait_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_no_emit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.emit) |-> (out_q.seq == 32'd0 && out_q.ack == 32'd0 &&
                                      out_q.flags == 8'd0 && out_q.plen == '0))
    else $error("segment fields set without emit");

  a_timeout_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_TIMEOUT) |-> out_q.phase == CodeClosed)
    else $error("timeout result not in closed phase");

  a_connect_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.op == OP_CONNECT) |=> (phase_q == PH_SYN_SENT && active_q))
    else $error("connect did not enter syn sent");

endmodule

// ----- src/tcp_client_connection_engine.sv -----
// Top level of the TCP client connection engine: configuration registers,
// front classifier, item queue and back executor. Depends on tcce_pkg.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o   | kind .. length
//   out     | output    | out_valid_o / out_stall_i | emit .. conn_phase
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One result per input beat; an accepted item passes through the queue
// into the output register. A new item is accepted every cycle while the queue
// has room. Throughput is set by the back end: one item a cycle when not stalled.
// The queue (QueueDepth entries) lets input beats land while the output stalls.
// Reset clears the connection state and loads the configuration defaults.
module tcp_client_connection_engine #(
  parameter int unsigned QueueDepth = tcce_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   kind_i,
  input  logic [31:0]                  peer_ip_i,
  input  logic [15:0]                  peer_port_i,
  input  logic [15:0]                  seg_dst_port_i,
  input  logic [31:0]                  seg_seq_i,
  input  logic [7:0]                   seg_flags_i,
  input  logic [3:0]                   seg_data_offset_i,
  input  logic [15:0]                  length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         emit_o,
  output logic [7:0]                   out_flags_o,
  output logic [31:0]                  out_seq_o,
  output logic [31:0]                  out_ack_o,
  output logic [15:0]                  out_src_port_o,
  output logic [15:0]                  out_dst_port_o,
  output logic [31:0]                  out_dst_ip_o,
  output logic [15:0]                  out_window_o,
  output logic [tcce_pkg::PlenW-1:0]   out_payload_length_o,
  output logic [2:0]                   status_o,
  output logic [2:0]                   conn_phase_o
);
  import tcce_pkg::*;

  tcce_cfg_t    cfg_q;
  tcce_item_t   push_item, head_item;
  tcce_result_t result;
  logic         q_full, q_push, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.client_port     <= ClientPortRst;
      cfg_q.initial_seq     <= InitialSeqRst;
      cfg_q.window_size     <= WindowRst;
      cfg_q.connect_timeout <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLIENT_PORT:     cfg_q.client_port     <= cfg_data_i[15:0];
        CFG_INITIAL_SEQ:     cfg_q.initial_seq     <= cfg_data_i;
        CFG_WINDOW_SIZE:     cfg_q.window_size     <= cfg_data_i[15:0];
        CFG_CONNECT_TIMEOUT: cfg_q.connect_timeout <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  tcce_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .peer_ip_i         (peer_ip_i),
    .peer_port_i       (peer_port_i),
    .seg_dst_port_i    (seg_dst_port_i),
    .seg_seq_i         (seg_seq_i),
    .seg_flags_i       (seg_flags_i),
    .seg_data_offset_i (seg_data_offset_i),
    .length_i          (length_i),
    .client_port_i     (cfg_q.client_port),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_item_o          (push_item)
  );

  tcce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (head_item)
  );

  tcce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign emit_o               = result.emit;
  assign out_flags_o          = result.flags;
  assign out_seq_o            = result.seq;
  assign out_ack_o            = result.ack;
  assign out_src_port_o       = result.src_port;
  assign out_dst_port_o       = result.dst_port;
  assign out_dst_ip_o         = result.dst_ip;
  assign out_window_o         = result.window;
  assign out_payload_length_o = result.plen;
  assign status_o             = result.status;
  assign conn_phase_o         = result.phase;

endmodule

// ----- bench/tb_tcp_client_connection_engine.sv -----
`timescale 1ns / 1ps
// Testbench of the TCP client connection engine: directed cases, then random sessions,
// each beat checked against an in-bench model of the connection. Needs tcce_pkg and the RTL.
module tb_tcp_client_connection_engine;
  import tcce_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldCycles    = 80;
  localparam logic [2:0]  KindUnused    = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_seq;
    logic [7:0]  seg_flags;
    logic [3:0]  seg_data_offset;
    logic [15:0] length;
  } conn_item_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i       = CFG_CLIENT_PORT;
  logic [31:0]        cfg_data_i        = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i            = OP_CONNECT;
  logic [31:0]        peer_ip_i         = '0;
  logic [15:0]        peer_port_i       = '0;
  logic [15:0]        seg_dst_port_i    = '0;
  logic [31:0]        seg_seq_i         = '0;
  logic [7:0]         seg_flags_i       = '0;
  logic [3:0]         seg_data_offset_i = '0;
  logic [15:0]        length_i          = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic               emit_o;
  logic [7:0]         out_flags_o;
  logic [31:0]        out_seq_o;
  logic [31:0]        out_ack_o;
  logic [15:0]        out_src_port_o;
  logic [15:0]        out_dst_port_o;
  logic [31:0]        out_dst_ip_o;
  logic [15:0]        out_window_o;
  logic [PlenW-1:0]   out_payload_length_o;
  logic [2:0]         status_o;
  logic [2:0]         conn_phase_o;

  // Connection model
  tcce_cfg_t   cfg_model;
  logic [2:0]  conn_phase_q;
  logic        conn_active;
  logic [31:0] conn_peer_ip;
  logic [15:0] conn_peer_port;
  logic [31:0] conn_snd_seq;
  logic [31:0] conn_rcv_ack;
  logic [15:0] conn_ticks;

  tcce_result_t expected_results[$];
  int unsigned  errors       = 0;
  int unsigned  items_sent   = 0;
  int unsigned  idle_cycles  = 0;
  int unsigned  hold_request = 0;
  bit           send_idle_en = 1'b1;
  bit           recv_idle_en = 1'b1;

  tcp_client_connection_engine dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .peer_ip_i           (peer_ip_i),
    .peer_port_i         (peer_port_i),
    .seg_dst_port_i      (seg_dst_port_i),
    .seg_seq_i           (seg_seq_i),
    .seg_flags_i         (seg_flags_i),
    .seg_data_offset_i   (seg_data_offset_i),
    .length_i            (length_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .emit_o              (emit_o),
    .out_flags_o         (out_flags_o),
    .out_seq_o           (out_seq_o),
    .out_ack_o           (out_ack_o),
    .out_src_port_o      (out_src_port_o),
    .out_dst_port_o      (out_dst_port_o),
    .out_dst_ip_o        (out_dst_ip_o),
    .out_window_o        (out_window_o),
    .out_payload_length_o(out_payload_length_o),
    .status_o            (status_o),
    .conn_phase_o        (conn_phase_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic tcce_result_t make_segment(logic [7:0] flags, logic [PlenW-1:0] plen);
    tcce_result_t seg;
    seg          = '0;
    seg.emit     = 1'b1;
    seg.flags    = flags;
    seg.seq      = conn_snd_seq;
    seg.ack      = flags[AckBit] ? conn_rcv_ack : 32'd0;
    seg.src_port = cfg_model.client_port;
    seg.dst_port = conn_peer_port;
    seg.dst_ip   = conn_peer_ip;
    seg.window   = cfg_model.window_size;
    seg.plen     = plen;
    seg.status   = ST_OK;
    return seg;
  endfunction

  // Advance the connection model by one item and return the result it gives.
  function automatic tcce_result_t engine_step(conn_item_t it);
    tcce_result_t res;
    logic [31:0]  hdr_len;
    logic [31:0]  seg_len;
    res        = '0;
    res.status = ST_IGNORED;
    hdr_len    = {26'd0, it.seg_data_offset, 2'b00};
    seg_len    = {16'd0, it.length};
    case (it.kind)
      OP_CONNECT: begin
        conn_peer_ip   = it.peer_ip;
        conn_peer_port = it.peer_port;
        conn_snd_seq   = cfg_model.initial_seq;
        conn_rcv_ack   = '0;
        conn_ticks     = '0;
        conn_phase_q   = CodeSynSent;
        conn_active    = 1'b1;
        res            = make_segment(FlSyn, '0);
        conn_snd_seq   = conn_snd_seq + 32'd1;
      end
      OP_SEND: begin
        if (conn_phase_q != CodeEstablished) begin
          res.status = ST_REFUSED;
        end else begin
          if (seg_len > MaxPayload) res.status = ST_TOO_LONG;
          else res = make_segment(FlPsh | FlAck, it.length[PlenW-1:0]);
          // sequence moves on even when the payload is dropped
          conn_snd_seq = conn_snd_seq + seg_len;
        end
      end
      OP_CLOSE: begin
        if (conn_phase_q == CodeEstablished) begin
          res          = make_segment(FlFin | FlAck, '0);
          conn_snd_seq = conn_snd_seq + 32'd1;
          conn_phase_q = CodeCloseWait;
        end
        conn_active = 1'b0;
      end
      OP_SEGMENT: begin
        if (seg_len >= HdrBytes && conn_active && it.seg_dst_port == cfg_model.client_port
            && it.peer_ip == conn_peer_ip) begin
          if (conn_phase_q == CodeSynSent) begin
            if (it.seg_flags[SynBit] && it.seg_flags[AckBit]) begin
              conn_rcv_ack = it.seg_seq + 32'd1;
              res          = make_segment(FlAck, '0);
              res.status   = ST_CONNECTED;
              conn_phase_q = CodeEstablished;
            end
          end else if (conn_phase_q == CodeEstablished && hdr_len >= HdrBytes
                       && hdr_len <= seg_len) begin
            if (seg_len > hdr_len) conn_rcv_ack = it.seg_seq + (seg_len - hdr_len);
            if (it.seg_flags[FinBit]) begin
              conn_rcv_ack = conn_rcv_ack + 32'd1;
              res          = make_segment(FlFin | FlAck, '0);
              conn_phase_q = CodeTimeWait;
            end else if (it.seg_flags[AckBit]) begin
              res = make_segment(FlAck, '0);
            end
            res.status = ST_OK;
          end
        end
      end
      OP_TICK: begin
        if (conn_phase_q == CodeSynSent) begin
          conn_ticks = conn_ticks + 16'd1;
          if (conn_ticks >= cfg_model.connect_timeout) begin
            conn_phase_q = CodeClosed;
            conn_active  = 1'b0;
            res.status   = ST_TIMEOUT;
          end else begin
            res.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    res.phase = conn_phase_q;
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Result side: draw a stall length per beat, then take the next beat and check it.
  initial begin : result_checker
    int unsigned  wait_n;
    tcce_result_t want;
    tcce_result_t got;
    forever begin
      wait_n = recv_idle_en ? $urandom_range(0, 15) : 0;
      if (hold_request != 0) begin
        wait_n       = hold_request;
        hold_request = 0;
      end
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.emit     = emit_o;
      got.flags    = out_flags_o;
      got.seq      = out_seq_o;
      got.ack      = out_ack_o;
      got.src_port = out_src_port_o;
      got.dst_port = out_dst_port_o;
      got.dst_ip   = out_dst_ip_o;
      got.window   = out_window_o;
      got.plen     = out_payload_length_o;
      got.status   = status_e'(status_o);
      got.phase    = conn_phase_o;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual status %0d",
                 $time, got.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("emit", 32'(want.emit), 32'(got.emit));
        check_field("out_flags", 32'(want.flags), 32'(got.flags));
        check_field("out_seq", want.seq, got.seq);
        check_field("out_ack", want.ack, got.ack);
        check_field("out_src_port", 32'(want.src_port), 32'(got.src_port));
        check_field("out_dst_port", 32'(want.dst_port), 32'(got.dst_port));
        check_field("out_dst_ip", want.dst_ip, got.dst_ip);
        check_field("out_window", 32'(want.window), 32'(got.window));
        check_field("out_payload_length", 32'(want.plen), 32'(got.plen));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("conn_phase", 32'(want.phase), 32'(got.phase));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(conn_item_t it);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= it.kind;
    peer_ip_i         <= it.peer_ip;
    peer_port_i       <= it.peer_port;
    seg_dst_port_i    <= it.seg_dst_port;
    seg_seq_i         <= it.seg_seq;
    seg_flags_i       <= it.seg_flags;
    seg_data_offset_i <= it.seg_data_offset;
    length_i          <= it.length;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(engine_step(it));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CLIENT_PORT:     cfg_model.client_port     = data[15:0];
      CFG_INITIAL_SEQ:     cfg_model.initial_seq     = data;
      CFG_WINDOW_SIZE:     cfg_model.window_size     = data[15:0];
      CFG_CONNECT_TIMEOUT: cfg_model.connect_timeout = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_config(logic [15:0] lport, logic [31:0] iseq, logic [15:0] win,
                              logic [15:0] tmo);
    drain_results();
    write_register(CFG_CLIENT_PORT, {16'd0, lport});
    write_register(CFG_INITIAL_SEQ, iseq);
    write_register(CFG_WINDOW_SIZE, {16'd0, win});
    write_register(CFG_CONNECT_TIMEOUT, {16'd0, tmo});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic conn_item_t random_item(logic [2:0] kind);
    conn_item_t it;
    it.kind            = kind;
    it.peer_ip         = $urandom;
    it.peer_port       = 16'($urandom_range(0, 65535));
    it.seg_dst_port    = 16'($urandom_range(0, 65535));
    it.seg_seq         = $urandom;
    it.seg_flags       = 8'($urandom_range(0, 255));
    it.seg_data_offset = 4'($urandom_range(0, 15));
    it.length          = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic connect_to(logic [31:0] ip, logic [15:0] port);
    conn_item_t it;
    it           = random_item(OP_CONNECT);
    it.peer_ip   = ip;
    it.peer_port = port;
    send_item(it);
  endtask

  task automatic send_data(logic [15:0] len);
    conn_item_t it;
    it        = random_item(OP_SEND);
    it.length = len;
    send_item(it);
  endtask

  task automatic close_conn();
    send_item(random_item(OP_CLOSE));
  endtask

  task automatic tick_once();
    send_item(random_item(OP_TICK));
  endtask

  task automatic recv_segment(logic [31:0] ip, logic [15:0] dport, logic [31:0] seq,
                              logic [7:0] flags, logic [3:0] doff, logic [15:0] len);
    conn_item_t it;
    it                 = random_item(OP_SEGMENT);
    it.peer_ip         = ip;
    it.seg_dst_port    = dport;
    it.seg_seq         = seq;
    it.seg_flags       = flags;
    it.seg_data_offset = doff;
    it.length          = len;
    send_item(it);
  endtask

  // One connection: connect, up to three ticks, SYN+ACK, traffic, then an ending or none.
  task automatic run_session();
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] lport;
    logic [3:0]  doff;
    logic [15:0] len;
    logic [7:0]  flags;
    ip    = $urandom;
    port  = 16'($urandom_range(0, 65535));
    lport = cfg_model.client_port;
    connect_to(ip, port);
    repeat ($urandom_range(0, 3)) tick_once();
    flags = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) != 0) flags = flags | FlSyn | FlAck;
    recv_segment(ip, lport, $urandom, flags, 4'($urandom_range(0, 15)),
                 16'($urandom_range(20, 1500)));
    repeat ($urandom_range(2, 12)) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          if ($urandom_range(0, 7) == 0) send_data(16'($urandom_range(MaxPayload + 1, 65535)));
          else send_data(16'($urandom_range(0, MaxPayload)));
        end
        2, 3, 4: begin
          if ($urandom_range(0, 9) == 0) doff = 4'($urandom_range(0, 15));
          else doff = 4'($urandom_range(5, 15));
          if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, 80));
          else len = 16'({doff, 2'b00}) + 16'($urandom_range(0, 1460));
          flags = 8'($urandom_range(0, 255)) & ~FlFin;
          if ($urandom_range(0, 3) != 0) flags = flags | FlAck;
          recv_segment(ip, lport, $urandom, flags, doff, len);
        end
        5: recv_segment(ip, lport, $urandom, FlAck, 4'd5, 16'd20);
        6: tick_once();
        default: send_item(random_item(3'($urandom_range(0, 7))));
      endcase
    end
    case ($urandom_range(0, 3))
      0: close_conn();
      1: begin
        doff = 4'($urandom_range(5, 15));
        recv_segment(ip, lport, $urandom, FlFin | FlAck, doff,
                     16'({doff, 2'b00}) + 16'($urandom_range(0, 200)));
      end
      2: begin
        close_conn();
        recv_segment(ip, lport, $urandom, FlAck, 4'd5, 16'd40);
      end
      default: ;  // leave it open, the next connect replaces it
    endcase
  endtask

  task automatic test_closed_phase();
    write_config(16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
    send_data(16'd10);
    close_conn();
    tick_once();
    // address and port match the stored peer and client port, but no connection is open
    recv_segment(32'd0, 16'd0, $urandom, FlSyn | FlAck, 4'd5, 16'd20);
    send_item(random_item(OP_NONE));
    send_item(random_item(KindUnused));
    connect_to(32'hFFFF_FFFF, 16'hFFFF);
    // zero timeout expires on the first tick
    tick_once();
  endtask

  task automatic test_handshake();
    write_config(16'hFFFF, 32'd0, 16'hFFFF, 16'hFFFF);
    connect_to(32'd0, 16'd0);
    tick_once();
    recv_segment(32'd0, 16'hFFFE, $urandom, FlSyn | FlAck, 4'd5, 16'd40);
    recv_segment(32'd1, 16'hFFFF, $urandom, FlSyn | FlAck, 4'd5, 16'd40);
    recv_segment(32'd0, 16'hFFFF, $urandom, FlSyn | FlAck, 4'd5, 16'd19);
    recv_segment(32'd0, 16'hFFFF, $urandom, FlSyn, 4'd5, 16'd20);
    recv_segment(32'd0, 16'hFFFF, 32'hFFFF_FFFF, FlSyn | FlAck, 4'd0, 16'd20);
  endtask

  task automatic test_established();
    send_data(16'd0);
    send_data(16'(MaxPayload));
    send_data(16'(MaxPayload + 1));
    send_data(16'hFFFF);
    recv_segment(32'd0, 16'hFFFF, $urandom, FlAck, 4'd4, 16'd100);
    recv_segment(32'd0, 16'hFFFF, $urandom, FlAck, 4'd15, 16'd59);
    recv_segment(32'd0, 16'hFFFF, $urandom, FlAck, 4'd15, 16'd60);
    recv_segment(32'd0, 16'hFFFF, $urandom, 8'h00, 4'd5, 16'd120);
    recv_segment(32'd0, 16'hFFFF, $urandom, FlFin | FlAck, 4'd5, 16'hFFFF);
    send_data(16'd10);
    close_conn();
  endtask

  task automatic test_close_paths();
    logic [31:0] ip;
    logic [15:0] port;
    ip   = $urandom;
    port = 16'($urandom_range(0, 65535));
    connect_to(ip, port);
    close_conn();
    recv_segment(ip, cfg_model.client_port, $urandom, FlSyn | FlAck, 4'd5, 16'd20);
    tick_once();
    connect_to(ip, port);
    recv_segment(ip, cfg_model.client_port, $urandom, FlSyn | FlAck, 4'd5, 16'd20);
    close_conn();
    recv_segment(ip, cfg_model.client_port, $urandom, FlAck, 4'd5, 16'd40);
  endtask

  // Hold the result side for a long stretch while beats keep coming back to back.
  task automatic test_backpressure();
    int unsigned target;
    target       = items_sent + 30;
    send_idle_en = 1'b0;
    hold_request = HoldCycles;
    while (items_sent < target) run_session();
    drain_results();
    send_idle_en = 1'b1;
  endtask

  task automatic test_random_sessions(int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) send_item(random_item(3'($urandom_range(0, 7))));
      else run_session();
    end
  endtask

  initial begin
    cfg_model.client_port     = ClientPortRst;
    cfg_model.initial_seq     = InitialSeqRst;
    cfg_model.window_size     = WindowRst;
    cfg_model.connect_timeout = TimeoutRst;
    conn_phase_q   = CodeClosed;
    conn_active    = 1'b0;
    conn_peer_ip   = '0;
    conn_peer_port = '0;
    conn_snd_seq   = '0;
    conn_rcv_ack   = '0;
    conn_ticks     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_closed_phase();
    test_handshake();
    test_established();
    test_close_paths();
    for (int p = 0; p < 4; p++) begin
      write_config(16'($urandom_range(0, 65535)), $urandom, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(1, 6)));
      send_idle_en = (p != 1);
      recv_idle_en = (p != 2);
      test_random_sessions(170);
      if (p == 0) test_backpressure();
    end
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tcce_pkg.sv
src/tcce_front.sv
src/tcce_queue.sv
src/tcce_back.sv
src/tcp_client_connection_engine.sv
bench/tb_tcp_client_connection_engine.sv
